// ----- hw/rtl/pcd_pkg.sv -----
`timescale 1ns / 1ps

package pcd_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK  = 3'd0,
    ST_LAT = 3'd1,
    ST_LON = 3'd2,
    ST_ODD = 3'd3,
    ST_BAD = 3'd4
  } status_e;

  // What the front hands to the back for one character.
  typedef enum logic [1:0] {
    EV_PAIR = 2'd0,
    EV_FAIL = 2'd1,
    EV_END  = 2'd2
  } ev_kind_e;

  // Configuration register indexes.
  localparam logic CFG_LAT_LIMIT = 1'b0;
  localparam logic CFG_LON_LIMIT = 1'b1;

  localparam int unsigned LatLimitW = 24;
  localparam int unsigned LonLimitW = 25;
  localparam int unsigned CfgDataW  = 25;
  localparam int unsigned LatW      = 25;
  localparam int unsigned LonW      = 26;
  localparam int unsigned DeltaW    = 32;

  localparam logic [LatLimitW-1:0] LatLimitRst = 24'd9000000;
  localparam logic [LonLimitW-1:0] LonLimitRst = 25'd18000000;

  localparam int unsigned EvDepthDef  = 4;
  localparam int unsigned ResDepthDef = 2;

  typedef struct packed {
    ev_kind_e                  kind;
    status_e                   status;
    logic                      last;
    logic signed [DeltaW-1:0]  lat_delta;
    logic signed [DeltaW-1:0]  lon_delta;
  } event_t;

  typedef struct packed {
    logic [LatW-1:0] latitude;
    logic [LonW-1:0] longitude;
    logic            has_point;
    status_e         status;
    logic            end_of_route;
  } result_t;

endpackage

// ----- hw/rtl/pcd_fifo.sv -----
`timescale 1ns / 1ps

module pcd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == AddrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == AddrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/pcd_front.sv -----
`timescale 1ns / 1ps

module pcd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      char_code_i,
  input  logic            last_char_i,
  output logic            ev_wr_o,
  output pcd_pkg::event_t ev_o
);

  localparam int unsigned DW = pcd_pkg::DeltaW;

  logic [DW-1:0] acc_q, acc_d;
  logic [2:0]    cnt_q, cnt_d;
  logic [DW-1:0] pend_q, pend_d;
  logic          expect_lon_q, expect_lon_d;
  logic          disc_q, disc_d;

  logic [7:0]    group8;
  logic [4:0]    chunk;
  logic          more;
  logic          bad_code;
  logic          overlong;
  logic [4:0]    shamt;
  logic [DW-1:0] acc_new;

  function automatic logic signed [DW-1:0] unzigzag(logic [DW-1:0] v);
    return $signed({1'b0, v[DW-1:1]} ^ {DW{v[0]}});
  endfunction

  assign group8   = char_code_i - 8'd63;
  assign chunk    = group8[4:0];
  assign more     = group8[5];
  assign bad_code = (char_code_i < 8'd63) || (char_code_i > 8'd126);
  assign overlong = (cnt_q == 3'd6) && (more || (chunk > 5'd3));
  assign shamt    = {cnt_q, 2'b00} + {2'b00, cnt_q};
  assign acc_new  = acc_q | ({{(DW-5){1'b0}}, chunk} << shamt);

  always_comb begin
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    expect_lon_d = expect_lon_q;
    disc_d       = disc_q;
    ev_wr_o      = 1'b0;
    ev_o.kind      = pcd_pkg::EV_END;
    ev_o.status    = pcd_pkg::ST_OK;
    ev_o.last      = last_char_i;
    ev_o.lat_delta = unzigzag(pend_q);
    ev_o.lon_delta = unzigzag(acc_new);
    if (accept_i) begin
      if (disc_q) begin
        ev_wr_o = last_char_i;
      end else if (bad_code || overlong) begin
        ev_wr_o     = 1'b1;
        ev_o.kind   = pcd_pkg::EV_FAIL;
        ev_o.status = pcd_pkg::ST_BAD;
        disc_d      = 1'b1;
      end else if (more) begin
        acc_d = acc_new;
        cnt_d = cnt_q + 1'b1;
        if (last_char_i) begin
          ev_wr_o     = 1'b1;
          ev_o.status = expect_lon_q ? pcd_pkg::ST_ODD : pcd_pkg::ST_OK;
        end
      end else begin
        acc_d = '0;
        cnt_d = '0;
        if (!expect_lon_q) begin
          pend_d       = acc_new;
          expect_lon_d = 1'b1;
          if (last_char_i) begin
            ev_wr_o     = 1'b1;
            ev_o.status = pcd_pkg::ST_ODD;
          end
        end else begin
          ev_wr_o      = 1'b1;
          ev_o.kind    = pcd_pkg::EV_PAIR;
          expect_lon_d = 1'b0;
          pend_d       = '0;
        end
      end
      // Every route ends on its last character, whatever happened before.
      if (last_char_i) begin
        acc_d        = '0;
        cnt_d        = '0;
        pend_d       = '0;
        expect_lon_d = 1'b0;
        disc_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      cnt_q        <= '0;
      pend_q       <= '0;
      expect_lon_q <= 1'b0;
      disc_q       <= 1'b0;
    end else begin
      acc_q        <= acc_d;
      cnt_q        <= cnt_d;
      pend_q       <= pend_d;
      expect_lon_q <= expect_lon_d;
      disc_q       <= disc_d;
    end
  end

endmodule

// ----- hw/rtl/pcd_back.sv -----
`timescale 1ns / 1ps

module pcd_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             ev_valid_i,
  input  pcd_pkg::event_t                  ev_i,
  output logic                             ev_rd_o,
  input  logic                             res_full_i,
  output logic                             res_wr_o,
  output pcd_pkg::result_t                 res_o,
  input  logic [pcd_pkg::LatLimitW-1:0]    lat_limit_i,
  input  logic [pcd_pkg::LonLimitW-1:0]    lon_limit_i
);

  localparam int unsigned LatW = pcd_pkg::LatW;
  localparam int unsigned LonW = pcd_pkg::LonW;
  localparam int unsigned DW   = pcd_pkg::DeltaW;
  localparam int unsigned SumW = DW + 2;

  logic signed [LatW-1:0] lat_q, lat_d;
  logic signed [LonW-1:0] lon_q, lon_d;
  logic                   disc_q, disc_d;

  logic signed [SumW-1:0] lat_sum, lon_sum;
  logic signed [SumW-1:0] lat_lim, lon_lim;
  logic                   lat_bad, lon_bad;
  logic                   go;

  assign lat_sum = {{(SumW-LatW){lat_q[LatW-1]}}, lat_q}
                 + {{(SumW-DW){ev_i.lat_delta[DW-1]}}, ev_i.lat_delta};
  assign lon_sum = {{(SumW-LonW){lon_q[LonW-1]}}, lon_q}
                 + {{(SumW-DW){ev_i.lon_delta[DW-1]}}, ev_i.lon_delta};
  assign lat_lim = $signed({{(SumW-pcd_pkg::LatLimitW){1'b0}}, lat_limit_i});
  assign lon_lim = $signed({{(SumW-pcd_pkg::LonLimitW){1'b0}}, lon_limit_i});
  assign lat_bad = (lat_sum > lat_lim) || (lat_sum < -lat_lim);
  assign lon_bad = (lon_sum > lon_lim) || (lon_sum < -lon_lim);

  assign go      = ev_valid_i && !res_full_i;
  assign ev_rd_o = go;

  always_comb begin
    lat_d    = lat_q;
    lon_d    = lon_q;
    disc_d   = disc_q;
    res_wr_o = 1'b0;
    res_o.latitude     = '0;
    res_o.longitude    = '0;
    res_o.has_point    = 1'b0;
    res_o.status       = pcd_pkg::ST_OK;
    res_o.end_of_route = ev_i.last;
    if (go) begin
      if (disc_q) begin
        res_wr_o = ev_i.last;
      end else begin
        res_wr_o = 1'b1;
        case (ev_i.kind)
          pcd_pkg::EV_PAIR: begin
            if (lat_bad) begin
              res_o.status = pcd_pkg::ST_LAT;
              disc_d       = 1'b1;
            end else if (lon_bad) begin
              res_o.status = pcd_pkg::ST_LON;
              disc_d       = 1'b1;
            end else begin
              lat_d           = lat_sum[LatW-1:0];
              lon_d           = lon_sum[LonW-1:0];
              res_o.latitude  = lat_sum[LatW-1:0];
              res_o.longitude = lon_sum[LonW-1:0];
              res_o.has_point = 1'b1;
            end
          end
          pcd_pkg::EV_FAIL: begin
            res_o.status = ev_i.status;
            disc_d       = 1'b1;
          end
          default: begin
            res_o.status = ev_i.status;
          end
        endcase
      end
      if (ev_i.last) begin
        lat_d  = '0;
        lon_d  = '0;
        disc_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q  <= '0;
      lon_q  <= '0;
      disc_q <= 1'b0;
    end else begin
      lat_q  <= lat_d;
      lon_q  <= lon_d;
      disc_q <= disc_d;
    end
  end

endmodule

// ----- hw/rtl/polyline_coordinate_decoder.sv -----
`timescale 1ns / 1ps

// Encoded polyline decoder. Text characters go in through a queue-like port:
// a beat is taken when push is high and full is low, with last_char_i marking
// the final character of a route. Results leave the same way: while empty is
// low the oldest result sits on the result ports, and pop takes it.
// A result appears for a completed coordinate pair, for the first error of a
// route and for the last character; other characters produce nothing.
// One character per cycle is sustained while full is low. A result reaches
// the ports through both queues: the front gathers chunks and decodes the
// sign in the cycle the character is taken and writes an event into a small
// event queue; the back takes the oldest event, adds the running sum, checks
// the range and queues the result. If the receiver stops popping, the result
// queue and then the event queue fill, and full rises; nothing is lost. Reset
// empties both queues, clears the route state and loads the default latitude
// and longitude limits. Unchecked by the block, the user must write limits
// through cfg_we_i/cfg_index_i/cfg_data_i only while the block is idle.
module polyline_coordinate_decoder #(
  parameter int unsigned EvDepth  = pcd_pkg::EvDepthDef,
  parameter int unsigned ResDepth = pcd_pkg::ResDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        char_code_i,
  input  logic                              last_char_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [pcd_pkg::LatW-1:0]   latitude_o,
  output logic signed [pcd_pkg::LonW-1:0]   longitude_o,
  output logic                              has_point_o,
  output logic [2:0]                        status_o,
  output logic                              end_of_route_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [pcd_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned EvW  = $bits(pcd_pkg::event_t);
  localparam int unsigned ResW = $bits(pcd_pkg::result_t);

  logic [pcd_pkg::LatLimitW-1:0] lat_limit_q;
  logic [pcd_pkg::LonLimitW-1:0] lon_limit_q;

  pcd_pkg::event_t  ev_in, ev_out;
  pcd_pkg::result_t res_in, res_out;
  logic [EvW-1:0]   ev_out_raw;
  logic [ResW-1:0]  res_out_raw;
  logic             ev_wr, ev_full, ev_empty, ev_rd;
  logic             res_wr, res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_limit_q <= pcd_pkg::LatLimitRst;
      lon_limit_q <= pcd_pkg::LonLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pcd_pkg::CFG_LAT_LIMIT: lat_limit_q <= cfg_data_i[pcd_pkg::LatLimitW-1:0];
        pcd_pkg::CFG_LON_LIMIT: lon_limit_q <= cfg_data_i[pcd_pkg::LonLimitW-1:0];
        default: ;
      endcase
    end
  end

  assign full = ev_full;

  pcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (push && !ev_full),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .ev_wr_o     (ev_wr),
    .ev_o        (ev_in)
  );

  pcd_fifo #(
    .Width (EvW),
    .Depth (EvDepth)
  ) u_ev_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (ev_wr),
    .wdata_i (ev_in),
    .full_o  (ev_full),
    .rd_i    (ev_rd),
    .rdata_o (ev_out_raw),
    .empty_o (ev_empty)
  );

  assign ev_out = pcd_pkg::event_t'(ev_out_raw);

  pcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (!ev_empty),
    .ev_i        (ev_out),
    .ev_rd_o     (ev_rd),
    .res_full_i  (res_full),
    .res_wr_o    (res_wr),
    .res_o       (res_in),
    .lat_limit_i (lat_limit_q),
    .lon_limit_i (lon_limit_q)
  );

  pcd_fifo #(
    .Width (ResW),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_out_raw),
    .empty_o (empty)
  );

  assign res_out        = pcd_pkg::result_t'(res_out_raw);
  assign latitude_o     = res_out.latitude;
  assign longitude_o    = res_out.longitude;
  assign has_point_o    = res_out.has_point;
  assign status_o       = res_out.status;
  assign end_of_route_o = res_out.end_of_route;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import pcd_pkg::*;

  typedef enum int {
    POP_ALWAYS,
    POP_COIN,
    POP_RARE,
    POP_BURSTY
  } pop_mode_e;

  // Encoded text characters used by the directed routes.
  localparam logic [7:0] CH_ZERO = 8'd63;   // value 0, no continuation
  localparam logic [7:0] CH_ONE  = 8'd65;   // value +1, no continuation
  localparam logic [7:0] CH_MORE = 8'd95;   // chunk 0 with continuation
  localparam logic [7:0] CH_TOP  = 8'd126;  // chunk 31 with continuation

  class route_tracker;
    longint   lat_limit;
    longint   lon_limit;
    bit [31:0] acc;
    bit [2:0]  chunks;
    longint   run_lat;
    longint   run_lon;
    bit [31:0] lat_pending;
    bit       want_lon;
    bit       skipping;
    result_t  due_results[$];
    int       errors;
    int       n_chars;
    int       n_live;
    int       n_points;
    int       n_routes;
    int       n_checked;
    int       by_status[8];

    function new();
      lat_limit = LatLimitRst;
      lon_limit = LonLimitRst;
      clear_route();
    endfunction

    function void clear_route();
      acc = '0;
      chunks = '0;
      run_lat = 0;
      run_lon = 0;
      lat_pending = '0;
      want_lon = 1'b0;
      skipping = 1'b0;
    endfunction

    function void set_limit(logic idx, logic [CfgDataW-1:0] val);
      if (idx == CFG_LAT_LIMIT) lat_limit = val[LatLimitW-1:0];
      else lon_limit = val[LonLimitW-1:0];
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function longint unzigzag(bit [31:0] v);
      bit [31:0] m;
      int s;
      m = (v >> 1) ^ (v[0] ? 32'hFFFF_FFFF : 32'h0);
      s = m;
      return s;
    endfunction

    function void add_result(longint lat, longint lon, bit pt, status_e st, bit fin);
      result_t r;
      r.latitude = lat[LatW-1:0];
      r.longitude = lon[LonW-1:0];
      r.has_point = pt;
      r.status = st;
      r.end_of_route = fin;
      due_results.push_back(r);
      by_status[st]++;
      if (pt) n_points++;
      if (fin) begin
        n_routes++;
        clear_route();
      end
    endfunction

    function void fail(status_e st, bit fin);
      skipping = 1'b1;
      add_result(0, 0, 1'b0, st, fin);
    endfunction

    function void take_char(logic [7:0] code, logic fin);
      bit [5:0]  grp;
      bit [4:0]  chunk;
      bit        more;
      bit [31:0] raw;
      longint    lat;
      longint    lon;
      n_chars++;
      if (skipping) begin
        if (fin) add_result(0, 0, 1'b0, ST_OK, 1'b1);
        return;
      end
      n_live++;
      if (code < 8'd63 || code > 8'd126) begin
        fail(ST_BAD, fin);
        return;
      end
      grp = code - 8'd63;
      chunk = grp[4:0];
      more = grp[5];
      // Seven chunks carry 35 bits; only the low 32 may be used.
      if (chunks == 3'd6 && (more || chunk > 5'd3)) begin
        fail(ST_BAD, fin);
        return;
      end
      acc |= 32'(chunk) << (5 * chunks);
      if (more) begin
        chunks++;
        if (fin) add_result(0, 0, 1'b0, want_lon ? ST_ODD : ST_OK, 1'b1);
        return;
      end
      raw = acc;
      acc = '0;
      chunks = '0;
      if (!want_lon) begin
        lat_pending = raw;
        want_lon = 1'b1;
        if (fin) add_result(0, 0, 1'b0, ST_ODD, 1'b1);
        return;
      end
      lat = run_lat + unzigzag(lat_pending);
      lon = run_lon + unzigzag(raw);
      want_lon = 1'b0;
      lat_pending = '0;
      if (lat > lat_limit || lat < -lat_limit) fail(ST_LAT, fin);
      else if (lon > lon_limit || lon < -lon_limit) fail(ST_LON, fin);
      else begin
        run_lat = lat;
        run_lon = lon;
        add_result(lat, lon, 1'b1, ST_OK, fin);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("tb: mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result lat %0d lon %0d point %0b status %0d",
                                  $signed(got.latitude), $signed(got.longitude),
                                  got.has_point, got.status));
        return;
      end
      want = due_results.pop_front();
      n_checked++;
      if (got.latitude !== want.latitude)
        report_mismatch($sformatf("result %0d latitude %0d, expected %0d", n_checked,
                                  $signed(got.latitude), $signed(want.latitude)));
      if (got.longitude !== want.longitude)
        report_mismatch($sformatf("result %0d longitude %0d, expected %0d", n_checked,
                                  $signed(got.longitude), $signed(want.longitude)));
      if (got.has_point !== want.has_point)
        report_mismatch($sformatf("result %0d has_point %0b, expected %0b", n_checked,
                                  got.has_point, want.has_point));
      if (got.status !== want.status)
        report_mismatch($sformatf("result %0d status %0d, expected %0d", n_checked,
                                  got.status, want.status));
      if (got.end_of_route !== want.end_of_route)
        report_mismatch($sformatf("result %0d end_of_route %0b, expected %0b", n_checked,
                                  got.end_of_route, want.end_of_route));
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       push;
  logic                       full;
  logic [7:0]                 char_code_i;
  logic                       last_char_i;
  logic                       empty;
  logic                       pop;
  logic signed [LatW-1:0]     latitude_o;
  logic signed [LonW-1:0]     longitude_o;
  logic                       has_point_o;
  logic [2:0]                 status_o;
  logic                       end_of_route_o;
  logic                       cfg_we_i;
  logic                       cfg_index_i;
  logic [CfgDataW-1:0]        cfg_data_i;

  route_tracker tracker;
  result_t      beat_out;
  logic [7:0]   route_text[$];
  bit           steady;
  int           burst_left;
  pop_mode_e    pop_mode;
  int           pop_left;

  polyline_coordinate_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .char_code_i    (char_code_i),
    .last_char_i    (last_char_i),
    .empty          (empty),
    .pop            (pop),
    .latitude_o     (latitude_o),
    .longitude_o    (longitude_o),
    .has_point_o    (has_point_o),
    .status_o       (status_o),
    .end_of_route_o (end_of_route_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Receiver: stall behavior switches between a few patterns every so often.
  always @(negedge clk_i) begin
    if (pop_left == 0) begin
      pop_mode = pop_mode_e'($urandom_range(0, 3));
      pop_left = $urandom_range(20, 80);
    end
    pop_left--;
    case (pop_mode)
      POP_ALWAYS: pop <= 1'b1;
      POP_COIN:   pop <= 1'($urandom_range(0, 1));
      POP_RARE:   pop <= ($urandom_range(0, 7) == 0);
      default:    pop <= (pop_left % 16) < 4;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) tracker.take_char(char_code_i, last_char_i);
      if (pop && !empty) begin
        beat_out.latitude = latitude_o;
        beat_out.longitude = longitude_o;
        beat_out.has_point = has_point_o;
        beat_out.status = status_e'(status_o);
        beat_out.end_of_route = end_of_route_o;
        tracker.check_result(beat_out);
      end
    end
  end

  task automatic idle_sender(int n);
    push <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic send_char(logic [7:0] code, logic fin);
    if (!steady && burst_left == 0) begin
      idle_sender($urandom_range(1, 6));
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    push <= 1'b1;
    char_code_i <= code;
    last_char_i <= fin;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // A character may still be in flight without producing a result, so the wait
  // goes on past the last expected beat.
  task automatic wait_drained();
    idle_sender(1);
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_limits(logic [CfgDataW-1:0] lat_lim, logic [CfgDataW-1:0] lon_lim);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_LAT_LIMIT;
    cfg_data_i <= lat_lim;
    @(negedge clk_i);
    cfg_index_i <= CFG_LON_LIMIT;
    cfg_data_i <= lon_lim;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_limit(CFG_LAT_LIMIT, lat_lim);
    tracker.set_limit(CFG_LON_LIMIT, lon_lim);
    @(negedge clk_i);
  endtask

  function automatic void add_value(int delta);
    bit [31:0] z;
    z = (delta < 0) ? ~(32'(delta) << 1) : (32'(delta) << 1);
    while (z >= 32'h20) begin
      route_text.push_back(8'(((z & 32'h1F) | 32'h20) + 32'd63));
      z = z >> 5;
    end
    route_text.push_back(8'(z + 32'd63));
  endfunction

  // Mostly small steps that keep a route alive, with some that land near or
  // past the limits and a few that use the whole 32-bit range.
  function automatic int pick_delta(int scale);
    int mag;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8: mag = $urandom_range(0, 200);
      9, 10, 11, 12:             mag = $urandom_range(0, 100000);
      13, 14, 15, 16, 17:        mag = $urandom_range(0, scale + scale / 4 + 1);
      18:                        return int'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       return 0;
          1:       return 1;
          2:       return -1;
          3:       return int'(32'h7FFF_FFFF);
          default: return int'(32'h8000_0000);
        endcase
      end
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic send_route(int scale);
    int npts;
    int cut;
    int kind;
    route_text.delete();
    kind = $urandom_range(0, 19);
    if (kind < 15) begin
      npts = $urandom_range(0, 6);
      repeat (npts) begin
        add_value(pick_delta(scale));
        add_value(pick_delta(scale));
      end
      if (kind < 12) begin
        case ($urandom_range(0, 9))
          0:       add_value(pick_delta(scale));
          1:       route_text.push_back(8'($urandom_range(95, 126)));
          default: ;
        endcase
      end else begin
        // Break the route somewhere, possibly in the middle of a value.
        cut = $urandom_range(0, route_text.size());
        while (route_text.size() > cut) void'(route_text.pop_back());
        case ($urandom_range(0, 2))
          0: route_text.push_back(8'($urandom_range(0, 1) ? $urandom_range(0, 62)
                                                          : $urandom_range(127, 255)));
          1: repeat (7) route_text.push_back(8'($urandom_range(95, 126)));
          default: begin
            repeat (6) route_text.push_back(8'($urandom_range(95, 126)));
            route_text.push_back(8'($urandom_range(67, 94)));
          end
        endcase
        add_value(pick_delta(scale));
        add_value(pick_delta(scale));
      end
    end else if (kind < 17) begin
      repeat ($urandom_range(1, 12)) route_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 20)) route_text.push_back(8'($urandom_range(63, 126)));
    end
    if (route_text.size() == 0) route_text.push_back(CH_ZERO);
    steady = ($urandom_range(0, 3) == 0);
    foreach (route_text[i]) send_char(route_text[i], i == route_text.size() - 1);
  endtask

  initial begin
    int quota;
    int scale;
    logic [CfgDataW-1:0] lat_set;
    logic [CfgDataW-1:0] lon_set;
    rst_ni = 1'b0;
    push = 1'b0;
    char_code_i = '0;
    last_char_i = 1'b0;
    pop = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_LAT_LIMIT;
    cfg_data_i = '0;
    steady = 1'b1;
    burst_left = 0;
    pop_left = 0;
    tracker = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed routes with the reset limits.
    send_char(CH_ZERO, 1'b1);
    send_char(CH_ZERO, 1'b0);
    send_char(CH_ZERO, 1'b1);
    send_char(8'd0, 1'b0);
    send_char(8'd255, 1'b0);
    send_char(CH_ZERO, 1'b1);
    send_char(CH_ZERO, 1'b0);
    send_char(CH_ZERO, 1'b0);
    send_char(CH_MORE, 1'b1);
    repeat (6) send_char(CH_TOP, 1'b0);
    send_char(CH_TOP, 1'b1);
    send_char(8'd127, 1'b1);
    send_char(8'd62, 1'b1);

    wait_drained();
    set_limits('0, LonLimitRst);
    send_char(CH_ONE, 1'b0);
    send_char(CH_ZERO, 1'b0);
    send_char(CH_ZERO, 1'b1);

    wait_drained();
    set_limits(LatLimitRst, '0);
    send_char(CH_ZERO, 1'b0);
    send_char(CH_ONE, 1'b1);

    quota = tracker.n_chars;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          lat_set = LatLimitRst;
          lon_set = LonLimitRst;
          quota += 300;
        end
        1: begin
          lat_set = '0;
          lon_set = '0;
          quota += 80;
        end
        2: begin
          lat_set = $urandom_range(50, 5000);
          lon_set = $urandom_range(50, 5000);
          quota += 200;
        end
        3: begin
          lat_set = LatLimitRst;
          lon_set = '0;
          quota += 80;
        end
        default: begin
          lat_set = $urandom_range(0, 9000000);
          lon_set = $urandom_range(0, 18000000);
          quota += 290;
        end
      endcase
      wait_drained();
      set_limits(lat_set, lon_set);
      scale = lat_set;
      while (tracker.n_chars < quota) begin
        send_route(scale);
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
    end

    idle_sender(1);
    for (int i = 0; i < 20000 && tracker.pending() != 0; i++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));

    $display("tb: %0d characters over %0d routes, %0d decoded and the rest skipped after errors",
             tracker.n_chars, tracker.n_routes, tracker.n_live);
    $display("tb: %0d results: %0d points, %0d lat/%0d lon range, %0d odd, %0d malformed",
             tracker.n_checked, tracker.n_points, tracker.by_status[ST_LAT],
             tracker.by_status[ST_LON], tracker.by_status[ST_ODD], tracker.by_status[ST_BAD]);
    if (tracker.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
